[rtl/sorted_bucket_hash_table_unit_assert.svh]
// Assertion macros shared by the sorted bucket hash table RTL
`ifndef SORTED_BUCKET_HASH_TABLE_UNIT_ASSERT_SVH
`define SORTED_BUCKET_HASH_TABLE_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define SBH_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SBH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/sbht_pkg.sv]
// Package: shared types and constants for the sorted bucket hash table
`default_nettype none
package sbht_pkg;
   localparam int MaxBuckets = 16;
   localparam int SlotsPerBucket = 8;
   localparam int BucketBits = $clog2(MaxBuckets);
   localparam int SlotBits = $clog2(SlotsPerBucket);
   localparam int FillBits = $clog2(SlotsPerBucket + 1);
   localparam int AddrBits = BucketBits + SlotBits;
   localparam int KeyBits = 31;
   localparam int SizeBits = 5;
   localparam int CountBits = 8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_FILL, S_RD, S_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_OUT
   } state_type;

   // Start strobe from the controller to the modulo unit
   typedef struct packed {
      logic start;
   } mod_ctl_type;
endpackage
`default_nettype wire

[rtl/sbht_mod.sv]
// Iterative restoring modulo of a key by the table size, one bit per cycle
`default_nettype none
module sbht_mod
   import sbht_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [KeyBits-1:0]    key,
   input  wire logic [SizeBits-1:0]   divisor,
   output logic                       done,
   output logic [BucketBits-1:0]      remainder
);
   logic [KeyBits-1:0]  key_ff, key_in;
   logic [SizeBits:0]   rem_ff, rem_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [SizeBits:0]   trial;

   always_comb begin
      key_in = key_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[SizeBits-1:0], key_ff[KeyBits-1]};
      if (start) begin
         key_in = key;
         rem_in = '0;
         cnt_in = 5'(KeyBits - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         key_in = {key_ff[KeyBits-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         if (cnt_ff == '0) busy_in = 1'b0;
         else cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      key_ff <= key_in;
      rem_ff <= rem_in;
   end

   // done pulses the cycle after the last step
   logic fin_ff;
   always_ff @(posedge clock) begin
      if (reset) fin_ff <= 1'b0;
      else fin_ff <= busy_ff && cnt_ff == '0 && !start;
   end
   assign done = fin_ff;
   assign remainder = rem_ff[BucketBits-1:0];
endmodule
`default_nettype wire

[rtl/sbht_ctrl.sv]
// Controller: bucket walk, insert/remove shifting over the key and fill memories
`default_nettype none
`include "sorted_bucket_hash_table_unit_assert.svh"
module sbht_ctrl
   import sbht_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [1:0]           req_op,
   input  wire logic [KeyBits-1:0]   req_key,
   output mod_ctl_type               mod_ctl,
   input  wire logic                 mod_done,
   input  wire logic [BucketBits-1:0] mod_rem,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [1:0]                rsp_status,
   output logic                      rsp_found,
   output logic [3:0]                rsp_accesses,
   output logic [CountBits-1:0]      rsp_count
);
   state_type state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [KeyBits-1:0]   key_ff, key_in;
   logic [BucketBits-1:0] bkt_ff, bkt_in;
   logic [FillBits-1:0]  fill_ff, fill_in, pos_ff, pos_in;
   logic [1:0]           status_ff, status_in;
   logic                 found_ff, found_in;
   logic [3:0]           acc_ff, acc_in;
   logic [CountBits-1:0] total_ff, total_in;

   // Key memory, one bucket per row of slots; fill memory per bucket
   logic [KeyBits-1:0]  key_mem [MaxBuckets*SlotsPerBucket];
   logic [FillBits-1:0] fill_mem [MaxBuckets];
   logic [MaxBuckets-1:0] fill_vld_ff;
   logic                key_we;
   logic [AddrBits-1:0] key_waddr, key_raddr;
   logic [KeyBits-1:0]  key_wdata, key_rdata_ff;
   logic                fill_we;
   logic [FillBits-1:0] fill_wdata, fill_rdata_ff;

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= key_wdata;
      key_rdata_ff <= key_mem[key_raddr];
      if (fill_we) fill_mem[bkt_ff] <= fill_wdata;
      fill_rdata_ff <= fill_vld_ff[bkt_ff] ? fill_mem[bkt_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         fill_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (fill_we) fill_vld_ff[bkt_ff] <= 1'b1;
      end
      op_ff <= op_in; key_ff <= key_in; bkt_ff <= bkt_in;
      fill_ff <= fill_in; pos_ff <= pos_in;
      status_ff <= status_in; found_ff <= found_in; acc_ff <= acc_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; key_in = key_ff; bkt_in = bkt_ff;
      fill_in = fill_ff; pos_in = pos_ff;
      status_in = status_ff; found_in = found_ff; acc_in = acc_ff;
      total_in = total_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mod_ctl = '0;
      key_we = 1'b0;
      key_waddr = {bkt_ff, pos_ff[SlotBits-1:0]};
      key_wdata = key_ff;
      key_raddr = {bkt_ff, pos_ff[SlotBits-1:0]};
      fill_we = 1'b0;
      fill_wdata = fill_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_op; key_in = req_key;
               status_in = ST_DONE; found_in = 1'b0; acc_in = '0;
               mod_ctl.start = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               bkt_in = mod_rem;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // fill read issued this cycle via bkt_ff; its result is used in S_RD
            pos_in = '0;
            state_in = S_RD;
         end
         S_RD: begin
            fill_in = fill_rdata_ff;
            if (op_ff != OP_INSERT && op_ff != OP_REMOVE && op_ff != OP_SEARCH) begin
               state_in = S_OUT;
            end else if (op_ff == OP_INSERT && fill_rdata_ff >= FillBits'(SlotsPerBucket)) begin
               status_in = ST_FULL;
               state_in = S_OUT;
            end else if (fill_rdata_ff == '0) begin
               if (op_ff == OP_INSERT) state_in = S_PUT;
               else begin status_in = ST_MISS; state_in = S_OUT; end
            end else state_in = S_CHK;
         end
         S_CHK: begin
            // key_rdata_ff holds slot pos_ff
            unique case (op_ff)
               OP_INSERT: begin
                  if (key_rdata_ff >= key_ff) begin
                     pos_in = fill_ff; state_in = S_SHIFT_RD;
                     if (fill_ff == pos_ff) state_in = S_PUT;
                     else pos_in = fill_ff - 1'b1;
                     key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
                     fill_in = pos_ff; // remember insert place in fill_ff
                     acc_in = 4'(pos_ff);
                     if (fill_ff == pos_ff) state_in = S_PUT;
                  end else if (pos_ff + 1'b1 == fill_ff) begin
                     pos_in = fill_ff; state_in = S_PUT;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
                  end
               end
               OP_REMOVE: begin
                  if (key_rdata_ff == key_ff) begin
                     found_in = 1'b1;
                     if (pos_ff + 1'b1 == fill_ff) begin
                        fill_we = 1'b1; fill_wdata = fill_ff - 1'b1;
                        total_in = total_ff - 1'b1;
                        state_in = S_OUT;
                     end else begin
                        pos_in = pos_ff + 1'b1;
                        key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
                        state_in = S_SHIFT_WR;
                     end
                  end else if (pos_ff + 1'b1 == fill_ff) begin
                     status_in = ST_MISS; state_in = S_OUT;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
                  end
               end
               default: begin
                  acc_in = acc_ff + 4'd1;
                  if (key_rdata_ff == key_ff) begin
                     found_in = 1'b1; state_in = S_OUT;
                  end else if (pos_ff + 1'b1 == fill_ff) begin
                     status_in = ST_MISS; state_in = S_OUT;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            // insert: key_rdata_ff = slot pos_ff, move to pos_ff+1
            key_we = 1'b1;
            key_waddr = {bkt_ff, SlotBits'(pos_ff + 1'b1)};
            key_wdata = key_rdata_ff;
            if (pos_ff == fill_ff) begin
               pos_in = fill_ff; state_in = S_PUT;
            end else begin
               pos_in = pos_ff - 1'b1;
               key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
            end
         end
         S_SHIFT_WR: begin
            // remove: key_rdata_ff = slot pos_ff, move to pos_ff-1
            key_we = 1'b1;
            key_waddr = {bkt_ff, SlotBits'(pos_ff - 1'b1)};
            key_wdata = key_rdata_ff;
            if (pos_ff + 1'b1 == fill_ff) begin
               fill_we = 1'b1; fill_wdata = fill_ff - 1'b1;
               total_in = total_ff - 1'b1;
               state_in = S_OUT;
            end else begin
               pos_in = pos_ff + 1'b1;
               key_raddr = {bkt_ff, pos_in[SlotBits-1:0]};
            end
         end
         S_PUT: begin
            // write the new key at its place; bucket fill comes from the fill read
            key_we = 1'b1;
            key_waddr = {bkt_ff, pos_ff[SlotBits-1:0]};
            fill_we = 1'b1;
            fill_wdata = FillBits'(fill_rdata_ff + 1'b1);
            total_in = total_ff + 1'b1;
            acc_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // insert shift set fill_ff to the place; put there once shifting ends
      if (state_ff == S_SHIFT_RD && pos_ff == fill_ff) pos_in = fill_ff;
   end

   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_accesses = acc_ff;
   assign rsp_count = total_ff;

   `SBH_ASSERT_IMPL(a_rsp_only_out, rsp_tvalid, state_ff == S_OUT)
   `SBH_ASSERT_IMPL(a_found_status, rsp_tvalid && rsp_found, rsp_status == ST_DONE)
   `SBH_ASSERT_NEXT(a_out_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_count))
endmodule
`default_nettype wire

[rtl/sorted_bucket_hash_table_unit.sv]
// Top level: sorted bucket hash table with request, response and CSR channels
// Usage:
//   req channel carries one operation (insert, remove, search) and a key.
//   rsp channel returns status, found, accesses and the element count.
//   csr channel writes table_size; write only while no request is open.
// Sequence: one request at a time. The modulo unit works through the 31
//   key bits, one per cycle, and then raises done; then come a fill read
//   and a fill check, then one compare per slot walked, one move per slot
//   shifted and a write of a new key, before rsp_tvalid rises. The next
//   request is taken in the cycle after the response is delivered.
// The key store is one synchronous RAM with a registered read; slot
//   walking and shifting share its single read and write port.
// Reset clears the fill valid bits, the element count and sets table_size
//   to 16; slot contents need no clearing.
// When the receiver stalls, the response is held and no new request is
//   taken until it is delivered.
`default_nettype none
module sorted_bucket_hash_table_unit
   import sbht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // [1:0] operation, [32:2] key
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [1:0] status, [2] found,
                                        // [6:3] accesses, [14:7] element_count
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data
);
   logic [SizeBits-1:0] size_ff;
   logic [SizeBits-1:0] eff_size;
   mod_ctl_type         mod_ctl;
   logic                mod_done;
   logic [BucketBits-1:0] mod_rem;
   logic [1:0]          st;
   logic                fnd;
   logic [3:0]          acc;
   logic [CountBits-1:0] cnt;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= SizeBits'(MaxBuckets);
      else if (csr_valid) size_ff <= csr_data;
   end
   assign csr_ready = 1'b1;
   assign eff_size = (size_ff == '0) ? SizeBits'(1) :
                     (size_ff > SizeBits'(MaxBuckets)) ? SizeBits'(MaxBuckets) : size_ff;

   sbht_mod u_mod (
      .clock, .reset, .start(mod_ctl.start), .key(req_tdata[32:2]),
      .divisor(eff_size), .done(mod_done), .remainder(mod_rem)
   );

   sbht_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(req_tdata[1:0]), .req_key(req_tdata[32:2]),
      .mod_ctl, .mod_done, .mod_rem,
      .rsp_tvalid, .rsp_tready,
      .rsp_status(st), .rsp_found(fnd), .rsp_accesses(acc), .rsp_count(cnt)
   );

   assign rsp_tdata = {1'b0, cnt, acc, fnd, st};
endmodule
`default_nettype wire
